// ===== design/i2crs_pkg.sv =====
// Shared codes and types for the I2C master register sequencer.
`timescale 1ns / 1ps
`default_nettype none

package i2crs_pkg;

  // Command codes on the request channel
  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_STATUS  = 3'd1;
  localparam logic [2:0] CMD_RX_DONE = 3'd2;
  localparam logic [2:0] CMD_TX_DONE = 3'd3;
  localparam logic [2:0] CMD_ERROR   = 3'd4;

  // Sequencer phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SB     = 3'd1;
  localparam logic [2:0] PH_TXSEL  = 3'd2;
  localparam logic [2:0] PH_REGTXE = 3'd3;
  localparam logic [2:0] PH_RSB    = 3'd4;
  localparam logic [2:0] PH_RXSEL  = 3'd5;
  localparam logic [2:0] PH_DMA    = 3'd6;
  localparam logic [2:0] PH_BTF    = 3'd7;

  // Status event codes
  localparam logic [2:0] EV_SB    = 3'd0;
  localparam logic [2:0] EV_TXSEL = 3'd1;
  localparam logic [2:0] EV_RXSEL = 3'd2;
  localparam logic [2:0] EV_TXE   = 3'd3;
  localparam logic [2:0] EV_BTF   = 3'd4;
  localparam logic [2:0] EV_NONE  = 3'd5;

  // Status flag bit positions
  localparam int SR_SB      = 0;
  localparam int SR_ADDR    = 1;
  localparam int SR_BTF     = 2;
  localparam int SR_HDR10   = 3;
  localparam int SR_TXE     = 4;
  localparam int SR_TIMEOUT = 5;

  // Decoded status events for one transaction
  typedef struct packed {
    logic [2:0] first;
    logic       txe;
    logic       btf;
    logic       timeout;
  } ev_t;

  // Result of one transaction
  typedef struct packed {
    logic       issue_start;
    logic       send_address;
    logic       send_data;
    logic [7:0] tx_byte;
    logic       enable_dma;
    logic       disable_dma;
    logic       issue_stop;
    logic       enable_peripheral;
    logic       disable_peripheral;
    logic       transfer_done;
    logic       release_bus;
    logic [2:0] state_code;
  } res_t;

endpackage

`default_nettype wire

// ===== design/i2crs_if.sv =====
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
`default_nettype none

interface i2crs_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic       read_not_write;
  logic [6:0] device_address;
  logic [7:0] register_index;
  logic [5:0] status_flags;
  logic [2:0] bus_flags;

  modport source (
    output valid, command, read_not_write, device_address, register_index,
           status_flags, bus_flags,
    input  ready
  );
  modport sink (
    input  valid, command, read_not_write, device_address, register_index,
           status_flags, bus_flags,
    output ready
  );
endinterface

interface i2crs_res_if;
  logic       valid;
  logic       ready;
  logic       issue_start;
  logic       send_address;
  logic       send_data;
  logic [7:0] tx_byte;
  logic       enable_dma;
  logic       disable_dma;
  logic       issue_stop;
  logic       enable_peripheral;
  logic       disable_peripheral;
  logic       transfer_done;
  logic       release_bus;
  logic [2:0] state_code;

  modport source (
    output valid, issue_start, send_address, send_data, tx_byte, enable_dma,
           disable_dma, issue_stop, enable_peripheral, disable_peripheral,
           transfer_done, release_bus, state_code,
    input  ready
  );
  modport sink (
    input  valid, issue_start, send_address, send_data, tx_byte, enable_dma,
           disable_dma, issue_stop, enable_peripheral, disable_peripheral,
           transfer_done, release_bus, state_code,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/i2crs_classify.sv =====
// Status flag decoder: splits controller flags into ordered events.
`timescale 1ns / 1ps
`default_nettype none

module i2crs_classify (
  input  wire logic [5:0]     status_flags,
  input  wire logic [2:0]     bus_flags,
  output i2crs_pkg::ev_t      ev
);

  logic busy_master;

  assign busy_master = bus_flags[0] & bus_flags[1];

  always_comb begin
    ev = '0;
    // Only one addressing-phase event per transaction, highest priority first
    if (status_flags[i2crs_pkg::SR_SB]) begin
      ev.first = i2crs_pkg::EV_SB;
    end else if (status_flags[i2crs_pkg::SR_HDR10] && busy_master) begin
      ev.first = i2crs_pkg::EV_NONE;
    end else if (status_flags[i2crs_pkg::SR_TXE] && status_flags[i2crs_pkg::SR_ADDR] &&
                 (bus_flags == 3'b111)) begin
      ev.first = i2crs_pkg::EV_TXSEL;
    end else if (status_flags[i2crs_pkg::SR_ADDR] && busy_master) begin
      ev.first = i2crs_pkg::EV_RXSEL;
    end else begin
      ev.first = i2crs_pkg::EV_NONE;
    end
    ev.txe     = status_flags[i2crs_pkg::SR_TXE];
    ev.btf     = status_flags[i2crs_pkg::SR_BTF];
    ev.timeout = status_flags[i2crs_pkg::SR_TIMEOUT];
  end

endmodule

`default_nettype wire

// ===== design/i2crs_seq.sv =====
// Sequencer state registers and the per-transaction next-state logic.
`timescale 1ns / 1ps
`default_nettype none

module i2crs_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           advance,
  input  wire logic [2:0]     command,
  input  wire logic           read_not_write,
  input  wire logic [6:0]     device_address,
  input  wire logic [7:0]     register_index,
  input  wire i2crs_pkg::ev_t ev,
  output i2crs_pkg::res_t     res
);

  logic [2:0] phase;
  logic       is_read;
  logic [6:0] target_address;
  logic [7:0] target_register;
  logic       latch_start;

  i2crs_pkg::res_t r1, r2, r3;

  function automatic i2crs_pkg::res_t finish(input i2crs_pkg::res_t base);
    i2crs_pkg::res_t r;
    r = base;
    r.transfer_done      = 1'b1;
    r.disable_dma        = 1'b1;
    r.issue_stop         = 1'b1;
    r.disable_peripheral = 1'b1;
    r.enable_peripheral  = 1'b1;
    r.release_bus        = 1'b1;
    r.state_code         = i2crs_pkg::PH_IDLE;
    return r;
  endfunction

  // One status event applied to one phase; state_code carries the new phase
  function automatic i2crs_pkg::res_t on_status(input logic [2:0] evc,
                                                input logic [2:0] ph,
                                                input logic       rd,
                                                input logic [6:0] addr,
                                                input logic [7:0] regi);
    i2crs_pkg::res_t r;
    r = '0;
    r.state_code = ph;
    case (ph)
      i2crs_pkg::PH_SB: begin
        if (evc == i2crs_pkg::EV_SB) begin
          r.send_address = 1'b1;
          r.tx_byte      = {addr, 1'b0};
          r.state_code   = i2crs_pkg::PH_TXSEL;
        end
      end
      i2crs_pkg::PH_TXSEL: begin
        if (evc == i2crs_pkg::EV_TXSEL) begin
          r.send_data  = 1'b1;
          r.tx_byte    = regi;
          r.state_code = i2crs_pkg::PH_REGTXE;
        end
      end
      i2crs_pkg::PH_REGTXE: begin
        if (evc == i2crs_pkg::EV_TXE) begin
          if (rd) begin
            r.issue_start = 1'b1;
            r.state_code  = i2crs_pkg::PH_RSB;
          end else begin
            r.enable_dma = 1'b1;
            r.state_code = i2crs_pkg::PH_DMA;
          end
        end
      end
      i2crs_pkg::PH_RSB: begin
        if (evc == i2crs_pkg::EV_SB) begin
          r.send_address = 1'b1;
          r.tx_byte      = {addr, 1'b1};
          r.state_code   = i2crs_pkg::PH_RXSEL;
        end
      end
      i2crs_pkg::PH_RXSEL: begin
        if (evc == i2crs_pkg::EV_RXSEL) begin
          r.enable_dma = 1'b1;
          r.state_code = i2crs_pkg::PH_DMA;
        end
      end
      i2crs_pkg::PH_BTF: begin
        if (evc == i2crs_pkg::EV_TXE || evc == i2crs_pkg::EV_BTF) begin
          r = finish(r);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Chain the three ordered status events through the phase
  always_comb begin
    r1 = on_status(ev.first, phase, is_read, target_address, target_register);
    r2 = on_status(ev.txe ? i2crs_pkg::EV_TXE : i2crs_pkg::EV_NONE, r1.state_code,
                   is_read, target_address, target_register);
    r3 = on_status(ev.btf ? i2crs_pkg::EV_BTF : i2crs_pkg::EV_NONE, r2.state_code,
                   is_read, target_address, target_register);
  end

  always_comb begin
    res         = '0;
    res.state_code = phase;
    latch_start = 1'b0;
    unique case (command)
      i2crs_pkg::CMD_START: begin
        if (phase == i2crs_pkg::PH_IDLE) begin
          latch_start           = 1'b1;
          res.enable_peripheral = 1'b1;
          res.issue_start       = 1'b1;
          res.state_code        = i2crs_pkg::PH_SB;
        end
      end
      i2crs_pkg::CMD_STATUS: begin
        // At most one event writes tx_byte, so a plain OR merges them
        res            = i2crs_pkg::res_t'(r1 | r2 | r3);
        res.state_code = r3.state_code;
      end
      i2crs_pkg::CMD_RX_DONE: begin
        if (phase == i2crs_pkg::PH_DMA) begin
          res = finish(res);
        end
      end
      i2crs_pkg::CMD_TX_DONE: begin
        if (phase == i2crs_pkg::PH_DMA) begin
          res.disable_dma = 1'b1;
          res.state_code  = i2crs_pkg::PH_BTF;
        end
      end
      i2crs_pkg::CMD_ERROR: begin
        if (ev.timeout) begin
          if (phase != i2crs_pkg::PH_IDLE) begin
            res.enable_peripheral = 1'b1;
            res.release_bus       = 1'b1;
            res.state_code        = i2crs_pkg::PH_IDLE;
          end
        end else begin
          res.issue_stop         = 1'b1;
          res.disable_peripheral = 1'b1;
          res.transfer_done      = 1'b1;
          res.enable_peripheral  = 1'b1;
          res.release_bus        = 1'b1;
          res.state_code         = i2crs_pkg::PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= i2crs_pkg::PH_IDLE;
      is_read         <= 1'b0;
      target_address  <= '0;
      target_register <= '0;
    end else if (advance) begin
      phase <= res.state_code;
      if (latch_start) begin
        is_read         <= read_not_write;
        target_address  <= device_address;
        target_register <= register_index;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/i2c_master_register_sequencer_top.sv =====
// Top level of the I2C master register sequencer: request and result stages.
//
//   channel   direction   contents
//   -------   ---------   -----------------------------------------------
//   request   sink        command, start parameters, status and bus flags
//   result    source      bus actions, tx byte, DMA/controller strobes, state
//
// One transaction is accepted per cycle while the result channel keeps taking
// results. The request register loads on acceptance, the result register loads
// from it when the request stage advances, and the result handshake follows.
// The phase register in the sequencer closes the only loop through the next-state logic.
// Synchronous active-high rst clears both stage valids and the sequencer state.
// When the result is not taken, the request register holds its transaction and
// request.ready drops only once both stages are full.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_register_sequencer_top (
  input  wire logic    clk,
  input  wire logic    rst,
  i2crs_req_if.sink    request,
  i2crs_res_if.source  result
);

  // Request stage
  logic       req_valid;
  logic [2:0] req_command;
  logic       req_read_not_write;
  logic [6:0] req_device_address;
  logic [7:0] req_register_index;
  logic [5:0] req_status_flags;
  logic [2:0] req_bus_flags;

  // Result stage
  logic            res_valid;
  i2crs_pkg::res_t res_q;

  logic            res_open;
  logic            advance;
  i2crs_pkg::ev_t  ev;
  i2crs_pkg::res_t res_d;

  // Move the request stage forward whenever the result register can take it
  assign res_open      = !res_valid || result.ready;
  assign advance       = req_valid && res_open;
  assign request.ready = !req_valid || res_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (request.ready) begin
      req_valid <= request.valid;
    end
  end

  // Capture payload on acceptance; hold it while stalled
  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      req_command        <= request.command;
      req_read_not_write <= request.read_not_write;
      req_device_address <= request.device_address;
      req_register_index <= request.register_index;
      req_status_flags   <= request.status_flags;
      req_bus_flags      <= request.bus_flags;
    end
  end

  i2crs_classify u_classify (
    .status_flags (req_status_flags),
    .bus_flags    (req_bus_flags),
    .ev           (ev)
  );

  i2crs_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .command        (req_command),
    .read_not_write (req_read_not_write),
    .device_address (req_device_address),
    .register_index (req_register_index),
    .ev             (ev),
    .res            (res_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_open) begin
      res_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Drive the result channel from the result register
  assign result.valid              = res_valid;
  assign result.issue_start        = res_q.issue_start;
  assign result.send_address       = res_q.send_address;
  assign result.send_data          = res_q.send_data;
  assign result.tx_byte            = res_q.tx_byte;
  assign result.enable_dma         = res_q.enable_dma;
  assign result.disable_dma        = res_q.disable_dma;
  assign result.issue_stop         = res_q.issue_stop;
  assign result.enable_peripheral  = res_q.enable_peripheral;
  assign result.disable_peripheral = res_q.disable_peripheral;
  assign result.transfer_done      = res_q.transfer_done;
  assign result.release_bus        = res_q.release_bus;
  assign result.state_code         = res_q.state_code;

`ifndef SYNTH
  // Address and register byte never go out in the same transaction
  a_one_send: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_q.send_address && res_q.send_data))
    else $error("address and data byte sent together");

  // Releasing the bus always leaves the sequencer idle
  a_release_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.release_bus) |-> (res_q.state_code == i2crs_pkg::PH_IDLE))
    else $error("bus released outside idle");

  // A finished transfer always releases the bus
  a_done_release: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.transfer_done) |-> res_q.release_bus)
    else $error("transfer done without bus release");

  // DMA is only enabled on the way into the DMA wait phase
  a_dma_phase: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.enable_dma) |-> (res_q.state_code == i2crs_pkg::PH_DMA))
    else $error("DMA enabled outside DMA phase");
`endif

endmodule

`default_nettype wire

// ===== test/i2c_master_register_sequencer_top_test.sv =====
// Self-checking testbench for the I2C master register sequencer top level.
`timescale 1ns / 1ps

module i2c_master_register_sequencer_top_test;

  // Command codes the block must ignore
  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int TRANSFER_ITEMS   = 1700;
  localparam int PRESSURE_AFTER   = 120;  // results checked before the long hold
  localparam int PRESSURE_CYCLES  = 100;
  localparam int DRAIN_LIMIT      = 20000;
  localparam int SETTLE_CYCLES    = 10;

  // One request transaction as the sender sees it
  typedef struct packed {
    logic [2:0] command;
    logic       read_not_write;
    logic [6:0] device_address;
    logic [7:0] register_index;
    logic [5:0] status_flags;
    logic [2:0] bus_flags;
  } req_item_t;

  // Predicts the bus actions of each request and checks them against the results.
  class transfer_checker;
    logic [2:0]      phase;
    logic            is_read;
    logic [6:0]      target_address;
    logic [7:0]      target_register;
    i2crs_pkg::res_t pending_actions[$];
    int              mismatches;
    int              requests_seen;
    int              results_checked;
    int              transfers_started;
    int              transfers_notified;
    int              timeout_drops;

    function new();
      phase = i2crs_pkg::PH_IDLE;
      is_read = 1'b0;
      target_address = '0;
      target_register = '0;
    endfunction

    function void go_idle(inout i2crs_pkg::res_t r);
      r.enable_peripheral = 1'b1;
      r.release_bus = 1'b1;
      phase = i2crs_pkg::PH_IDLE;
    endfunction

    function void complete(inout i2crs_pkg::res_t r);
      r.transfer_done = 1'b1;
      r.disable_dma = 1'b1;
      r.issue_stop = 1'b1;
      r.disable_peripheral = 1'b1;
      go_idle(r);
    endfunction

    function void put_address(inout i2crs_pkg::res_t r, input logic dir);
      r.send_address = 1'b1;
      r.tx_byte = {target_address, dir};
    endfunction

    // Apply one decoded status event to the current phase
    function void advance(input logic [2:0] ev, inout i2crs_pkg::res_t r);
      case (phase)
        i2crs_pkg::PH_SB: begin
          if (ev == i2crs_pkg::EV_SB) begin
            put_address(r, 1'b0);
            phase = i2crs_pkg::PH_TXSEL;
          end
        end
        i2crs_pkg::PH_TXSEL: begin
          if (ev == i2crs_pkg::EV_TXSEL) begin
            r.send_data = 1'b1;
            r.tx_byte = target_register;
            phase = i2crs_pkg::PH_REGTXE;
          end
        end
        i2crs_pkg::PH_REGTXE: begin
          if (ev == i2crs_pkg::EV_TXE) begin
            if (is_read) begin
              r.issue_start = 1'b1;
              phase = i2crs_pkg::PH_RSB;
            end else begin
              r.enable_dma = 1'b1;
              phase = i2crs_pkg::PH_DMA;
            end
          end
        end
        i2crs_pkg::PH_RSB: begin
          if (ev == i2crs_pkg::EV_SB) begin
            put_address(r, 1'b1);
            phase = i2crs_pkg::PH_RXSEL;
          end
        end
        i2crs_pkg::PH_RXSEL: begin
          if (ev == i2crs_pkg::EV_RXSEL) begin
            r.enable_dma = 1'b1;
            phase = i2crs_pkg::PH_DMA;
          end
        end
        i2crs_pkg::PH_BTF: begin
          if (ev == i2crs_pkg::EV_TXE || ev == i2crs_pkg::EV_BTF) complete(r);
        end
        default: ;
      endcase
    endfunction

    function i2crs_pkg::res_t next_bus_actions(req_item_t it);
      i2crs_pkg::res_t r;
      logic            busy_master;
      logic [2:0]      first;
      logic [5:0]      sf;
      r = '0;
      sf = it.status_flags;
      busy_master = it.bus_flags[0] && it.bus_flags[1];
      case (it.command)
        i2crs_pkg::CMD_START: begin
          if (phase == i2crs_pkg::PH_IDLE) begin
            is_read = it.read_not_write;
            target_address = it.device_address;
            target_register = it.register_index;
            r.enable_peripheral = 1'b1;
            r.issue_start = 1'b1;
            phase = i2crs_pkg::PH_SB;
            transfers_started++;
          end
        end
        i2crs_pkg::CMD_STATUS: begin
          // Start sent wins, then the 10-bit header masks the address events
          first = i2crs_pkg::EV_NONE;
          if (sf[i2crs_pkg::SR_SB]) first = i2crs_pkg::EV_SB;
          else if (sf[i2crs_pkg::SR_HDR10] && busy_master) first = i2crs_pkg::EV_NONE;
          else if (sf[i2crs_pkg::SR_ADDR] && sf[i2crs_pkg::SR_TXE] && it.bus_flags == 3'b111)
            first = i2crs_pkg::EV_TXSEL;
          else if (sf[i2crs_pkg::SR_ADDR] && busy_master) first = i2crs_pkg::EV_RXSEL;
          if (first != i2crs_pkg::EV_NONE) advance(first, r);
          if (sf[i2crs_pkg::SR_TXE]) advance(i2crs_pkg::EV_TXE, r);
          if (sf[i2crs_pkg::SR_BTF]) advance(i2crs_pkg::EV_BTF, r);
        end
        i2crs_pkg::CMD_RX_DONE: begin
          if (phase == i2crs_pkg::PH_DMA) complete(r);
        end
        i2crs_pkg::CMD_TX_DONE: begin
          if (phase == i2crs_pkg::PH_DMA) begin
            r.disable_dma = 1'b1;
            phase = i2crs_pkg::PH_BTF;
          end
        end
        i2crs_pkg::CMD_ERROR: begin
          if (sf[i2crs_pkg::SR_TIMEOUT]) begin
            if (phase != i2crs_pkg::PH_IDLE) begin
              go_idle(r);
              timeout_drops++;
            end
          end else begin
            r.issue_stop = 1'b1;
            r.disable_peripheral = 1'b1;
            r.transfer_done = 1'b1;
            go_idle(r);
          end
        end
        default: ;
      endcase
      r.state_code = phase;
      return r;
    endfunction

    function void note_request(req_item_t it);
      pending_actions.push_back(next_bus_actions(it));
      requests_seen++;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(i2crs_pkg::res_t got);
      i2crs_pkg::res_t want;
      if (pending_actions.size() == 0) begin
        $display("%0t: result with no request outstanding, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = pending_actions.pop_front();
      results_checked++;
      if (got.transfer_done === 1'b1) transfers_notified++;
      compare_field("issue_start", 8'(want.issue_start), 8'(got.issue_start));
      compare_field("send_address", 8'(want.send_address), 8'(got.send_address));
      compare_field("send_data", 8'(want.send_data), 8'(got.send_data));
      compare_field("tx_byte", want.tx_byte, got.tx_byte);
      compare_field("enable_dma", 8'(want.enable_dma), 8'(got.enable_dma));
      compare_field("disable_dma", 8'(want.disable_dma), 8'(got.disable_dma));
      compare_field("issue_stop", 8'(want.issue_stop), 8'(got.issue_stop));
      compare_field("enable_peripheral", 8'(want.enable_peripheral),
                    8'(got.enable_peripheral));
      compare_field("disable_peripheral", 8'(want.disable_peripheral),
                    8'(got.disable_peripheral));
      compare_field("transfer_done", 8'(want.transfer_done), 8'(got.transfer_done));
      compare_field("release_bus", 8'(want.release_bus), 8'(got.release_bus));
      compare_field("state_code", 8'(want.state_code), 8'(got.state_code));
    endfunction
  endclass

  logic clk;
  logic rst;

  i2crs_req_if request_ch();
  i2crs_res_if result_ch();

  i2c_master_register_sequencer_top u_top (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch)
  );

  transfer_checker tracker = new();

  int transfer_items = 0;   // transactions sent as part of well-formed transfers
  int sender_calm = 0;      // remaining transactions offered back to back
  int receiver_calm = 0;    // remaining receiver rounds without a stall
  bit pressure_done = 1'b0;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly no gap, often a short one, now and then a long one. A calm
  // stretch forces zero gaps for a while so back-to-back traffic also occurs.
  function automatic int idle_length(inout int calm_left);
    int pick;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (pick < 65) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_item_t any_request();
    req_item_t it;
    it.command = 3'($urandom_range(0, 7));
    it.read_not_write = 1'($urandom_range(0, 1));
    it.device_address = 7'($urandom_range(0, 127));
    it.register_index = 8'($urandom_range(0, 255));
    it.status_flags = 6'($urandom_range(0, 63));
    it.bus_flags = 3'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic req_item_t make_request(logic [2:0] command, logic rnw, logic [6:0] addr,
                                             logic [7:0] index, logic [5:0] sf, logic [2:0] bf);
    req_item_t it;
    it.command = command;
    it.read_not_write = rnw;
    it.device_address = addr;
    it.register_index = index;
    it.status_flags = sf;
    it.bus_flags = bf;
    return it;
  endfunction

  // Offer one transaction after a random gap and hold it until it is taken.
  // Returns at the accepting edge so the next call can follow without a bubble.
  task automatic send_request(input req_item_t it);
    int gap;
    gap = idle_length(sender_calm);
    if (gap > 0) begin
      request_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_ch.valid <= 1'b1;
    request_ch.command <= it.command;
    request_ch.read_not_write <= it.read_not_write;
    request_ch.device_address <= it.device_address;
    request_ch.register_index <= it.register_index;
    request_ch.status_flags <= it.status_flags;
    request_ch.bus_flags <= it.bus_flags;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
  endtask

  // Walk one register write or read through the controller events in order,
  // with random don't-care bits. Now and then slip in a stray transaction or
  // cut the transfer short with an error.
  task automatic run_transfer(input bit rd);
    req_item_t plan[$];
    req_item_t it;
    bit        rx_finish;

    it = any_request();
    it.command = i2crs_pkg::CMD_START;
    it.read_not_write = rd;
    plan.push_back(it);

    it = any_request();
    it.command = i2crs_pkg::CMD_STATUS;
    it.status_flags[i2crs_pkg::SR_SB] = 1'b1;
    plan.push_back(it);

    // Transmitter addressed always carries tx empty, so the register byte
    // phase resolves in the same transaction
    it = any_request();
    it.command = i2crs_pkg::CMD_STATUS;
    it.status_flags[i2crs_pkg::SR_SB] = 1'b0;
    it.status_flags[i2crs_pkg::SR_HDR10] = 1'b0;
    it.status_flags[i2crs_pkg::SR_ADDR] = 1'b1;
    it.status_flags[i2crs_pkg::SR_TXE] = 1'b1;
    it.bus_flags = 3'b111;
    plan.push_back(it);

    if (rd) begin
      it = any_request();
      it.command = i2crs_pkg::CMD_STATUS;
      it.status_flags[i2crs_pkg::SR_SB] = 1'b1;
      plan.push_back(it);

      // Receiver addressed: keep it from looking like transmitter addressed
      it = any_request();
      it.command = i2crs_pkg::CMD_STATUS;
      it.status_flags[i2crs_pkg::SR_SB] = 1'b0;
      it.status_flags[i2crs_pkg::SR_HDR10] = 1'b0;
      it.status_flags[i2crs_pkg::SR_ADDR] = 1'b1;
      it.bus_flags[1:0] = 2'b11;
      if (it.bus_flags[2]) it.status_flags[i2crs_pkg::SR_TXE] = 1'b0;
      plan.push_back(it);
    end

    rx_finish = rd ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 4) == 0);
    if (rx_finish) begin
      it = any_request();
      it.command = i2crs_pkg::CMD_RX_DONE;
      plan.push_back(it);
    end else begin
      it = any_request();
      it.command = i2crs_pkg::CMD_TX_DONE;
      plan.push_back(it);
      it = any_request();
      it.command = i2crs_pkg::CMD_STATUS;
      if (!it.status_flags[i2crs_pkg::SR_BTF] && !it.status_flags[i2crs_pkg::SR_TXE])
        it.status_flags[i2crs_pkg::SR_BTF] = 1'b1;
      plan.push_back(it);
    end

    foreach (plan[k]) begin
      if ($urandom_range(0, 99) < 5) send_request(any_request());
      if ($urandom_range(0, 99) < 2) begin
        it = any_request();
        it.command = i2crs_pkg::CMD_ERROR;
        send_request(it);
        break;
      end
      send_request(plan[k]);
      transfer_items++;
    end
  endtask

  // Watch both channels at each edge; values here are the ones before the edge
  always @(posedge clk) begin : watch
    req_item_t       seen;
    i2crs_pkg::res_t got;
    if (!rst) begin
      if (request_ch.valid && request_ch.ready) begin
        seen.command = request_ch.command;
        seen.read_not_write = request_ch.read_not_write;
        seen.device_address = request_ch.device_address;
        seen.register_index = request_ch.register_index;
        seen.status_flags = request_ch.status_flags;
        seen.bus_flags = request_ch.bus_flags;
        tracker.note_request(seen);
      end
      if (result_ch.valid && result_ch.ready) begin
        got.issue_start = result_ch.issue_start;
        got.send_address = result_ch.send_address;
        got.send_data = result_ch.send_data;
        got.tx_byte = result_ch.tx_byte;
        got.enable_dma = result_ch.enable_dma;
        got.disable_dma = result_ch.disable_dma;
        got.issue_stop = result_ch.issue_stop;
        got.enable_peripheral = result_ch.enable_peripheral;
        got.disable_peripheral = result_ch.disable_peripheral;
        got.transfer_done = result_ch.transfer_done;
        got.release_bus = result_ch.release_bus;
        got.state_code = result_ch.state_code;
        tracker.check_result(got);
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off once traffic is
  // flowing so both stages fill and request.ready has to drop
  initial begin : receiver
    int stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = idle_length(receiver_calm);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      if (!pressure_done && tracker.results_checked >= PRESSURE_AFTER) begin
        pressure_done = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    req_item_t directed[$];
    req_item_t it;
    int        pick;
    int        waited;

    rst <= 1'b1;
    request_ch.valid <= 1'b0;
    request_ch.command <= i2crs_pkg::CMD_START;
    request_ch.read_not_write <= 1'b0;
    request_ch.device_address <= '0;
    request_ch.register_index <= '0;
    request_ch.status_flags <= '0;
    request_ch.bus_flags <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Errors and ignored codes while idle
    directed.push_back(make_request(i2crs_pkg::CMD_ERROR, 1'b0, '0, '0, 6'h00, 3'b000));
    directed.push_back(make_request(i2crs_pkg::CMD_ERROR, 1'b0, '0, '0, 6'h20, 3'b000));
    directed.push_back(make_request(CMD_SPARE_5, 1'b1, 7'h7F, 8'hFF, 6'h3F, 3'b111));
    directed.push_back(make_request(CMD_SPARE_6, 1'b1, 7'h7F, 8'hFF, 6'h3F, 3'b111));
    directed.push_back(make_request(CMD_SPARE_7, 1'b1, 7'h7F, 8'hFF, 6'h3F, 3'b111));
    directed.push_back(make_request(i2crs_pkg::CMD_STATUS, 1'b0, '0, '0, 6'h3F, 3'b111));
    // Register write at the top address and index, with a start while busy,
    // a 10-bit header with timeout set, and completion on byte finished
    directed.push_back(make_request(i2crs_pkg::CMD_START, 1'b0, 7'h7F, 8'hFF, 6'h00, 3'b000));
    directed.push_back(make_request(i2crs_pkg::CMD_START, 1'b1, 7'h00, 8'h00, 6'h3F, 3'b111));
    directed.push_back(make_request(i2crs_pkg::CMD_STATUS, 1'b0, '0, '0, 6'h28, 3'b011));
    directed.push_back(make_request(i2crs_pkg::CMD_STATUS, 1'b0, '0, '0, 6'h01, 3'b000));
    directed.push_back(make_request(i2crs_pkg::CMD_STATUS, 1'b0, '0, '0, 6'h12, 3'b111));
    directed.push_back(make_request(i2crs_pkg::CMD_TX_DONE, 1'b0, '0, '0, 6'h00, 3'b000));
    directed.push_back(make_request(i2crs_pkg::CMD_STATUS, 1'b0, '0, '0, 6'h04, 3'b000));
    // Register read at address and index zero, through the repeated start
    directed.push_back(make_request(i2crs_pkg::CMD_START, 1'b1, 7'h00, 8'h00, 6'h00, 3'b000));
    directed.push_back(make_request(i2crs_pkg::CMD_STATUS, 1'b0, '0, '0, 6'h01, 3'b000));
    directed.push_back(make_request(i2crs_pkg::CMD_STATUS, 1'b0, '0, '0, 6'h12, 3'b111));
    directed.push_back(make_request(i2crs_pkg::CMD_STATUS, 1'b0, '0, '0, 6'h3F, 3'b111));
    directed.push_back(make_request(i2crs_pkg::CMD_STATUS, 1'b0, '0, '0, 6'h02, 3'b011));
    directed.push_back(make_request(i2crs_pkg::CMD_RX_DONE, 1'b0, '0, '0, 6'h00, 3'b000));
    // Timeout while busy, then a plain error in mid transfer
    directed.push_back(make_request(i2crs_pkg::CMD_START, 1'b0, 7'h55, 8'hAA, 6'h00, 3'b000));
    directed.push_back(make_request(i2crs_pkg::CMD_ERROR, 1'b0, '0, '0, 6'h20, 3'b000));
    directed.push_back(make_request(i2crs_pkg::CMD_START, 1'b1, 7'h2A, 8'h55, 6'h00, 3'b000));
    directed.push_back(make_request(i2crs_pkg::CMD_STATUS, 1'b0, '0, '0, 6'h01, 3'b000));
    directed.push_back(make_request(i2crs_pkg::CMD_ERROR, 1'b0, '0, '0, 6'h00, 3'b000));

    foreach (directed[k]) send_request(directed[k]);

    // Mostly well-formed transfers, some raw noise, some stray errors
    while (transfer_items < TRANSFER_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        run_transfer(1'($urandom_range(0, 1)));
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 4)) send_request(any_request());
      end else begin
        it = any_request();
        it.command = i2crs_pkg::CMD_ERROR;
        send_request(it);
      end
    end
    request_ch.valid <= 1'b0;

    // Drain every outstanding result, then let the pipeline settle
    waited = 0;
    while (tracker.pending_actions.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (tracker.pending_actions.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.pending_actions.size());
      tracker.mismatches++;
    end

    $display("Covered %0d requests and %0d results: %0d transfers started,",
             tracker.requests_seen, tracker.results_checked, tracker.transfers_started);
    $display("%0d ended with notice, %0d dropped on timeout, %0d field mismatches.",
             tracker.transfers_notified, tracker.timeout_drops, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
